// ===== sv/escape_sequence_decoder_unit_assert.svh =====
// Assertion macros for the escape sequence decoder.
`ifndef ESCAPE_SEQUENCE_DECODER_UNIT_ASSERT_SVH
`define ESCAPE_SEQUENCE_DECODER_UNIT_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent.
`define ESD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define ESD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/esd_pkg.sv =====
`timescale 1ns / 1ps

package esd_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESCAPE = 3'd1,
        MODE_HEX    = 3'd2,
        MODE_OCTAL  = 3'd3,
        MODE_RAW    = 3'd4
    } mode_t;

    // One decoded step: up to two bytes, or a bare end marker.
    typedef struct packed {
        logic       two;
        logic       has_char;
        logic [7:0] char0;
        logic [7:0] char1;
        logic       last;
    } job_t;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LB     = 8'h62;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_LN     = 8'h6E;
    localparam logic [7:0] CH_LR     = 8'h72;
    localparam logic [7:0] CH_LT     = 8'h74;
    localparam logic [7:0] CH_LV     = 8'h76;
    localparam logic [7:0] CH_LX     = 8'h78;

    localparam logic [7:0] CC_BEL = 8'h07;
    localparam logic [7:0] CC_BS  = 8'h08;
    localparam logic [7:0] CC_HT  = 8'h09;
    localparam logic [7:0] CC_LF  = 8'h0A;
    localparam logic [7:0] CC_VT  = 8'h0B;
    localparam logic [7:0] CC_FF  = 8'h0C;
    localparam logic [7:0] CC_CR  = 8'h0D;

endpackage

// ===== sv/esd_front.sv =====
`timescale 1ns / 1ps

module esd_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    in_char,
    input  logic          in_end,
    output logic          push,
    output esd_pkg::job_t push_data
);
    import esd_pkg::*;

    mode_t      mode_reg, mode_next, mode_step;
    logic [1:0] cnt_reg, cnt_next, cnt_step;
    logic [7:0] acc_reg, acc_next, acc_step;

    logic       hex_ok;
    logic [3:0] hex_digit;
    logic       oct_ok;
    logic [7:0] hex_acc;
    logic [7:0] oct_acc;
    logic [1:0] cnt_inc;
    logic       esc_simple;
    logic [7:0] esc_byte;

    logic [1:0] emit_cnt;
    logic [7:0] byte0;
    logic [7:0] byte1;

    always_comb
    begin
        hex_ok    = 1'b1;
        hex_digit = 4'd0;
        if (in_char >= CH_ZERO && in_char <= CH_NINE)
            hex_digit = 4'(in_char - CH_ZERO);
        else if (in_char >= CH_LA && in_char <= CH_LF)
            hex_digit = 4'(in_char - CH_LA + 8'd10);
        else if (in_char >= CH_UA && in_char <= CH_UF)
            hex_digit = 4'(in_char - CH_UA + 8'd10);
        else
            hex_ok = 1'b0;
    end

    assign oct_ok  = (in_char >= CH_ZERO) && (in_char <= CH_SEVEN);
    assign hex_acc = {acc_reg[3:0], hex_digit};
    // '0'..'7' carry their digit value in the low three bits
    assign oct_acc = {acc_reg[4:0], in_char[2:0]};
    assign cnt_inc = cnt_reg + 2'd1;

    always_comb
    begin
        esc_simple = 1'b1;
        esc_byte   = in_char;
        unique case (in_char)
            CH_LA:     esc_byte = CC_BEL;
            CH_LB:     esc_byte = CC_BS;
            CH_LF:     esc_byte = CC_FF;
            CH_LN:     esc_byte = CC_LF;
            CH_LR:     esc_byte = CC_CR;
            CH_LT:     esc_byte = CC_HT;
            CH_LV:     esc_byte = CC_VT;
            CH_BSLASH: esc_byte = CH_BSLASH;
            CH_QUOTE:  esc_byte = CH_QUOTE;
            CH_DQUOTE: esc_byte = CH_DQUOTE;
            default:   esc_simple = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        mode_step = mode_reg;
        cnt_step  = cnt_reg;
        acc_step  = acc_reg;
        unique case (mode_reg)
            MODE_ESCAPE:
            begin
                mode_step = MODE_NORMAL;
                if (in_char == CH_LX)
                begin
                    mode_step = MODE_HEX;
                    cnt_step  = 2'd0;
                    acc_step  = 8'd0;
                end
                else if (oct_ok)
                begin
                    mode_step = MODE_OCTAL;
                    cnt_step  = 2'd1;
                    acc_step  = {5'd0, in_char[2:0]};
                end
                else if (!esc_simple)
                    mode_step = MODE_RAW;
            end
            MODE_HEX:
            begin
                if (hex_ok && cnt_inc < 2'd2)
                begin
                    cnt_step = cnt_inc;
                    acc_step = hex_acc;
                end
                else
                begin
                    cnt_step  = 2'd0;
                    acc_step  = 8'd0;
                    mode_step = (!hex_ok && in_char == CH_BSLASH) ? MODE_ESCAPE : MODE_NORMAL;
                end
            end
            MODE_OCTAL:
            begin
                if (oct_ok && cnt_inc < 2'd3)
                begin
                    cnt_step = cnt_inc;
                    acc_step = oct_acc;
                end
                else
                begin
                    cnt_step  = 2'd0;
                    acc_step  = 8'd0;
                    mode_step = (!oct_ok && in_char == CH_BSLASH) ? MODE_ESCAPE : MODE_NORMAL;
                end
            end
            MODE_RAW:
                mode_step = MODE_RAW;
            default:
                mode_step = (in_char == CH_BSLASH) ? MODE_ESCAPE : MODE_NORMAL;
        endcase

        // end of string: back to the reset state
        if (in_end)
        begin
            mode_next = MODE_NORMAL;
            cnt_next  = 2'd0;
            acc_next  = 8'd0;
        end
        else
        begin
            mode_next = mode_step;
            cnt_next  = cnt_step;
            acc_next  = acc_step;
        end
    end

    // emitted bytes
    always_comb
    begin
        emit_cnt = 2'd0;
        byte0    = 8'd0;
        byte1    = 8'd0;
        unique case (mode_reg)
            MODE_ESCAPE:
            begin
                if (esc_simple)
                begin
                    byte0    = esc_byte;
                    emit_cnt = 2'd1;
                end
                else if (in_char != CH_LX && !oct_ok)
                begin
                    byte0    = in_char;
                    emit_cnt = 2'd1;
                end
            end
            MODE_HEX:
            begin
                if (hex_ok)
                begin
                    if (cnt_inc >= 2'd2)
                    begin
                        byte0    = hex_acc;
                        emit_cnt = 2'd1;
                    end
                end
                else
                begin
                    byte0    = acc_reg;
                    emit_cnt = 2'd1;
                    if (in_char != CH_BSLASH)
                    begin
                        byte1    = in_char;
                        emit_cnt = 2'd2;
                    end
                end
            end
            MODE_OCTAL:
            begin
                if (oct_ok)
                begin
                    if (cnt_inc >= 2'd3)
                    begin
                        byte0    = oct_acc;
                        emit_cnt = 2'd1;
                    end
                end
                else
                begin
                    byte0    = acc_reg;
                    emit_cnt = 2'd1;
                    if (in_char != CH_BSLASH)
                    begin
                        byte1    = in_char;
                        emit_cnt = 2'd2;
                    end
                end
            end
            MODE_RAW:
            begin
                byte0    = in_char;
                emit_cnt = 2'd1;
            end
            default:
            begin
                if (in_char != CH_BSLASH)
                begin
                    byte0    = in_char;
                    emit_cnt = 2'd1;
                end
            end
        endcase

        // flush a pending digit run; such a step has emitted nothing yet
        if (in_end && emit_cnt == 2'd0 && (mode_step == MODE_HEX || mode_step == MODE_OCTAL))
        begin
            byte0    = acc_step;
            emit_cnt = 2'd1;
        end
    end

    assign push               = accept && (emit_cnt != 2'd0 || in_end);
    assign push_data.two      = (emit_cnt == 2'd2);
    assign push_data.has_char = (emit_cnt != 2'd0);
    assign push_data.char0    = byte0;
    assign push_data.char1    = byte1;
    assign push_data.last     = in_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            cnt_reg  <= 2'd0;
            acc_reg  <= 8'd0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

// ===== sv/esd_fifo.sv =====
`timescale 1ns / 1ps

module esd_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  esd_pkg::job_t push_data,
    input  logic          pop,
    output esd_pkg::job_t pop_data,
    output logic          full,
    output logic          empty
);
    import esd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== sv/esd_back.sv =====
`timescale 1ns / 1ps

module esd_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          empty,
    input  esd_pkg::job_t head,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    out_char,
    output logic          has_char,
    output logic          out_end
);
    import esd_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg, out_char_next;
    logic       has_char_reg, has_char_next;
    logic       out_end_reg, out_end_next;
    logic       sec_valid_reg, sec_valid_next;
    logic [7:0] sec_char_reg, sec_char_next;
    logic       sec_end_reg, sec_end_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        pop            = 1'b0;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        has_char_next  = has_char_reg;
        out_end_next   = out_end_reg;
        sec_valid_next = sec_valid_reg;
        sec_char_next  = sec_char_reg;
        sec_end_next   = sec_end_reg;
        if (slot_free)
        begin
            if (sec_valid_reg)
            begin
                // drain the second byte of a two-byte step
                out_valid_next = 1'b1;
                out_char_next  = sec_char_reg;
                has_char_next  = 1'b1;
                out_end_next   = sec_end_reg;
                sec_valid_next = 1'b0;
            end
            else if (!empty)
            begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                out_char_next  = head.char0;
                has_char_next  = head.has_char;
                out_end_next   = head.last && !head.two;
                sec_valid_next = head.two;
                sec_char_next  = head.char1;
                sec_end_next   = head.last;
            end
            else
                out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sec_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sec_valid_reg <= sec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        has_char_reg <= has_char_next;
        out_end_reg  <= out_end_next;
        sec_char_reg <= sec_char_next;
        sec_end_reg  <= sec_end_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign has_char  = has_char_reg;
    assign out_end   = out_end_reg;

endmodule

// ===== sv/escape_sequence_decoder_unit.sv =====
// A result passes through the step queue and the output register after the word
// that causes it is accepted. One input word per cycle while in_stall is low; a word that
// decodes to two bytes gives two results; the QUEUE_DEPTH-entry step queue absorbs that.
// Reset: rst_n, asynchronous, active low, returns the decoder to normal mode and
// empties the queue and the output register.
`timescale 1ns / 1ps

module escape_sequence_decoder_unit
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_char,
    input  logic       in_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       has_char,
    output logic       out_end
);
    import esd_pkg::*;

    logic accept;
    logic push;
    logic pop;
    logic full;
    logic empty;
    job_t push_data;
    job_t head;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    esd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_char   (in_char),
        .in_end    (in_end),
        .push      (push),
        .push_data (push_data)
    );

    esd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (head),
        .full      (full),
        .empty     (empty)
    );

    esd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .has_char  (has_char),
        .out_end   (out_end)
    );

endmodule

// ===== sv/esd_checker.sv =====
`timescale 1ns / 1ps
`include "escape_sequence_decoder_unit_assert.svh"

module esd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_char,
    input logic       has_char,
    input logic       out_end
);

    logic       held;
    logic       bare;
    logic [9:0] out_word;

    assign held     = out_valid && out_stall;
    assign bare     = out_valid && !has_char;
    assign out_word = {out_char, has_char, out_end};

    // a held result keeps its word
    `ESD_ASSERT_NEXT(a_out_hold, held, out_valid && $stable(out_word), "held word changed")

    // a result without a byte only closes a string
    `ESD_ASSERT_NOW(a_bare_is_end, bare, out_end, "bare result without end mark")

    `ESD_ASSERT_NOW(a_bare_zero, bare, out_char == 8'd0, "bare result carries a byte")

endmodule

bind escape_sequence_decoder_unit esd_checker u_esd_checker (.*);
